[rtl/core/pixel_average_gamma_to_rgb8_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for pixel_average_gamma_to_rgb8
// Clocked concurrent assertion wrappers; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef PIXEL_AVERAGE_GAMMA_TO_RGB8_ASSERT_SVH
`define PIXEL_AVERAGE_GAMMA_TO_RGB8_ASSERT_SVH

`ifndef SYNTHESIS
`define PAGR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PAGR_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PAGR_ASSERT(lbl, clk, rst_n, prop, msg)
`define PAGR_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

[rtl/core/pagr_pkg.sv]
// ----------------------------------------------------------------------------
// pagr_pkg
// Payload types and fixed constants of the pixel resolve pipeline.
// ----------------------------------------------------------------------------
package pagr_pkg;

  localparam int unsigned ChanWidth = 32;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned DivWidth  = 16;
  localparam int unsigned NumChan   = 3;
  localparam int unsigned RootBits  = 8;
  localparam int unsigned SqWidth   = 32;
  localparam int unsigned OddWidth  = RootBits + 1;
  localparam int unsigned ProdWidth = OddWidth + DivWidth;

  localparam int unsigned ChanRed   = 0;
  localparam int unsigned ChanGreen = 1;
  localparam int unsigned ChanBlue  = 2;

  typedef struct packed {
    logic [ChanWidth-1:0] red_sum;
    logic [ChanWidth-1:0] green_sum;
    logic [ChanWidth-1:0] blue_sum;
  } pix_sum_t;

  typedef struct packed {
    logic [ByteWidth-1:0] red_byte;
    logic [ByteWidth-1:0] green_byte;
    logic [ByteWidth-1:0] blue_byte;
  } pix_rgb_t;

endpackage

[rtl/core/pagr_root_stage.sv]
// ----------------------------------------------------------------------------
// pagr_root_stage
// One restoring square-root step per channel: decides root bit BIT by
// testing (r + 2^BIT)^2 * d <= sum with an incrementally kept r^2 * d.
// ----------------------------------------------------------------------------
module pagr_root_stage #(
  parameter int unsigned SUM_WIDTH = 32,
  parameter int unsigned BIT       = 7
) (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  en_i,
  input  logic                                                  valid_i,
  input  logic [pagr_pkg::DivWidth-1:0]                         div_i,
  input  logic [pagr_pkg::NumChan-1:0][SUM_WIDTH-1:0]           sum_i,
  input  logic [pagr_pkg::NumChan-1:0][pagr_pkg::RootBits-1:0]  root_i,
  input  logic [pagr_pkg::NumChan-1:0][pagr_pkg::SqWidth-1:0]   sq_i,
  output logic                                                  valid_o,
  output logic [pagr_pkg::NumChan-1:0][SUM_WIDTH-1:0]           sum_o,
  output logic [pagr_pkg::NumChan-1:0][pagr_pkg::RootBits-1:0]  root_o,
  output logic [pagr_pkg::NumChan-1:0][pagr_pkg::SqWidth-1:0]   sq_o
);

  localparam int unsigned CmpWidth =
    (SUM_WIDTH > pagr_pkg::SqWidth) ? SUM_WIDTH : pagr_pkg::SqWidth;

  logic                                                  valid_q;
  logic [pagr_pkg::NumChan-1:0][SUM_WIDTH-1:0]           sum_q;
  logic [pagr_pkg::NumChan-1:0][pagr_pkg::RootBits-1:0]  root_q, root_d;
  logic [pagr_pkg::NumChan-1:0][pagr_pkg::SqWidth-1:0]   sq_q, sq_d;

  logic [pagr_pkg::NumChan-1:0][pagr_pkg::OddWidth-1:0]  odd;
  logic [pagr_pkg::NumChan-1:0][pagr_pkg::ProdWidth-1:0] prod;
  logic [pagr_pkg::NumChan-1:0][CmpWidth-1:0]            trial;
  logic [pagr_pkg::NumChan-1:0]                          take;

  // (r + b)^2 d = r^2 d + ((2r | b) * d) << BIT, with b = 2^BIT
  always_comb begin
    for (int c = 0; c < pagr_pkg::NumChan; c++) begin
      odd[c]    = (pagr_pkg::OddWidth'(root_i[c]) << 1)
                | (pagr_pkg::OddWidth'(1) << BIT);
      prod[c]   = pagr_pkg::ProdWidth'(odd[c]) * pagr_pkg::ProdWidth'(div_i);
      trial[c]  = CmpWidth'(sq_i[c]) + (CmpWidth'(prod[c]) << BIT);
      take[c]   = trial[c] <= CmpWidth'(sum_i[c]);
      root_d[c] = take[c] ? (root_i[c] | (pagr_pkg::RootBits'(1) << BIT)) : root_i[c];
      sq_d[c]   = take[c] ? trial[c][pagr_pkg::SqWidth-1:0] : sq_i[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      sum_q  <= sum_i;
      root_q <= root_d;
      sq_q   <= sq_d;
    end
  end

  assign valid_o = valid_q;
  assign sum_o   = sum_q;
  assign root_o  = root_q;
  assign sq_o    = sq_q;

endmodule

[rtl/core/pixel_average_gamma_to_rgb8.sv]
// ----------------------------------------------------------------------------
// Pipeline: one register stage per root bit between input and result.
// Throughput: one pixel per cycle; a stage stalls only when it and every stage
//   downstream of it are full and the output is not ready.
// Reset: all stage valids clear, the sample count returns to 1.
// ----------------------------------------------------------------------------
// pixel_average_gamma_to_rgb8
// Resolves accumulated Q16.16 channel sums into gamma-2 8-bit color:
// min(isqrt(sum / samples), 255), computed without a divider as the largest
// r with r^2 * samples <= sum.
// ----------------------------------------------------------------------------
`include "pixel_average_gamma_to_rgb8_assert.svh"

module pixel_average_gamma_to_rgb8 #(
  parameter int unsigned SUM_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pagr_pkg::DivWidth-1:0] cfg_data_i,
  input  logic                          pix_valid_i,
  output logic                          pix_ready_o,
  input  pagr_pkg::pix_sum_t            pix_i,
  output logic                          rgb_valid_o,
  input  logic                          rgb_ready_i,
  output pagr_pkg::pix_rgb_t            rgb_o
);

  localparam int unsigned NStage = pagr_pkg::RootBits;

  logic [pagr_pkg::DivWidth-1:0] div_q, div_d;

  logic [NStage:0]                                         valid_s;
  logic [NStage-1:0]                                       en_s;
  logic [pagr_pkg::NumChan-1:0][SUM_WIDTH-1:0]             sum_s  [NStage+1];
  logic [pagr_pkg::NumChan-1:0][pagr_pkg::RootBits-1:0]    root_s [NStage+1];
  logic [pagr_pkg::NumChan-1:0][pagr_pkg::SqWidth-1:0]     sq_s   [NStage+1];
  logic [pagr_pkg::NumChan-1:0]                            root_fits;

  // zero sample count acts as one
  assign div_d       = (cfg_data_i == '0) ? pagr_pkg::DivWidth'(1) : cfg_data_i;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q <= pagr_pkg::DivWidth'(1);
    end else if (cfg_valid_i) begin
      div_q <= div_d;
    end
  end

  assign valid_s[0]                   = pix_valid_i;
  assign sum_s[0][pagr_pkg::ChanRed]   = SUM_WIDTH'(pix_i.red_sum);
  assign sum_s[0][pagr_pkg::ChanGreen] = SUM_WIDTH'(pix_i.green_sum);
  assign sum_s[0][pagr_pkg::ChanBlue]  = SUM_WIDTH'(pix_i.blue_sum);
  assign root_s[0]                    = '0;
  assign sq_s[0]                      = '0;

  assign en_s[NStage-1] = !valid_s[NStage] || rgb_ready_i;

  for (genvar k = 0; k < NStage; k++) begin : g_stage
    if (k < NStage - 1) begin : g_en
      assign en_s[k] = !valid_s[k+1] || en_s[k+1];
    end

    pagr_root_stage #(
      .SUM_WIDTH (SUM_WIDTH),
      .BIT       (NStage - 1 - k)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_s[k]),
      .valid_i (valid_s[k]),
      .div_i   (div_q),
      .sum_i   (sum_s[k]),
      .root_i  (root_s[k]),
      .sq_i    (sq_s[k]),
      .valid_o (valid_s[k+1]),
      .sum_o   (sum_s[k+1]),
      .root_o  (root_s[k+1]),
      .sq_o    (sq_s[k+1])
    );
  end

  assign pix_ready_o      = en_s[0];
  assign rgb_valid_o      = valid_s[NStage];
  assign rgb_o.red_byte   = root_s[NStage][pagr_pkg::ChanRed];
  assign rgb_o.green_byte = root_s[NStage][pagr_pkg::ChanGreen];
  assign rgb_o.blue_byte  = root_s[NStage][pagr_pkg::ChanBlue];

  always_comb begin
    for (int c = 0; c < pagr_pkg::NumChan; c++) begin
      root_fits[c] = 64'(sq_s[NStage][c]) <= 64'(sum_s[NStage][c]);
    end
  end

  `PAGR_ASSERT_NEVER(a_div_nonzero, clk_i, rst_ni, div_q == '0, "divisor register is zero")
  `PAGR_ASSERT(a_ready_drained, clk_i, rst_ni, !rgb_valid_o |-> pix_ready_o, "stall while empty")
  `PAGR_ASSERT(a_root_fits, clk_i, rst_ni, rgb_valid_o |-> &root_fits, "root squared exceeds sum")

endmodule
